/* hw/rtl/rhcb_pkg.sv */
// Shared types, constants and helper functions for the rolling hash chunk boundary finder.
`default_nettype none

package rhcb_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
    localparam int HASH_W     = 63;
    localparam int LEN_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 63;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_BITS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_BITS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_VALUE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHUNK   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK   = 3'd6;

    localparam logic [1:0] REASON_HASH = 2'd0;
    localparam logic [1:0] REASON_MAX  = 2'd1;
    localparam logic [1:0] REASON_END  = 2'd2;

    typedef struct packed {
        logic [HASH_W-1:0] multiplier;
        logic [5:0]        hash_bits;
        logic [6:0]        window_len;
        logic [5:0]        match_bits;
        logic [31:0]       match_value;
        logic [LEN_W-1:0]  min_chunk;
        logic [LEN_W-1:0]  max_chunk;
    } cfg_t;

    // One message byte as queued for the back end; left counts the bytes after it.
    typedef struct packed {
        logic [7:0]       data_byte;
        logic             msg_start;
        logic             msg_end;
        logic [LEN_W-1:0] left;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WLOOP,
        ST_WWAIT,
        ST_READ,
        ST_HMUL,
        ST_DEC
    } back_state_t;

    function automatic logic [WIN_W-1:0] win_len(input logic [6:0] wl);
        logic [WIN_W-1:0] n;
        if (wl == 7'd0) begin
            n = WIN_W'(1);
        end else if (int'(wl) > MAX_WINDOW) begin
            n = WIN_W'(MAX_WINDOW);
        end else begin
            n = WIN_W'(wl);
        end
        return n;
    endfunction

    function automatic logic [HASH_W-1:0] low_mask(input logic [5:0] bits);
        logic [63:0] t;
        t = (64'd1 << bits) - 64'd1;
        return t[HASH_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rhcb_front.sv */
// Front end: accepts byte requests, tracks message bytes left and queues live bytes.
`default_nettype none

module rhcb_front (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [7:0]               s_data_byte,
    input  wire logic                     s_first_of_message,
    input  wire logic [rhcb_pkg::LEN_W-1:0] s_message_length,
    input  wire logic                     fifo_full,
    output logic                          push,
    output rhcb_pkg::item_t               push_item
);

    logic [rhcb_pkg::LEN_W-1:0] left_reg;
    logic [rhcb_pkg::LEN_W-1:0] left_next;
    logic [rhcb_pkg::LEN_W-1:0] left_eff;
    logic [rhcb_pkg::LEN_W-1:0] left_after;
    logic                       accept;
    logic                       live;

    assign s_ready    = !fifo_full;
    assign accept     = s_valid && s_ready;
    assign left_eff   = s_first_of_message ? s_message_length : left_reg;
    assign live       = (left_eff != '0);
    assign left_after = left_eff - 1'b1;
    assign push       = accept && live;

    always_comb begin
        left_next = left_reg;
        if (accept) begin
            left_next = live ? left_after : '0;
        end
    end

    always_comb begin
        push_item.data_byte = s_data_byte;
        push_item.msg_start = s_first_of_message;
        push_item.msg_end   = (left_after == '0);
        push_item.left      = left_after;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else begin
            left_reg <= left_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rhcb_fifo.sv */
// Short queue of classified bytes between the front end and the back end.
`default_nettype none

module rhcb_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire rhcb_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 empty,
    output rhcb_pkg::item_t      head_item
);

    rhcb_pkg::item_t                 fifo_mem [rhcb_pkg::FIFO_DEPTH];
    logic [rhcb_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [rhcb_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [rhcb_pkg::FIFO_PTR_W:0]   count_reg;
    logic [rhcb_pkg::FIFO_PTR_W:0]   count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full      = (count_reg == (rhcb_pkg::FIFO_PTR_W + 1)'(rhcb_pkg::FIFO_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = fifo_mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            fifo_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rhcb_mul.sv */
// Multiplier giving the low 63 bits of a 63 by 63 product from three 32 by 32 partial products.
`default_nettype none

module rhcb_mul (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [rhcb_pkg::HASH_W-1:0] a_in,
    input  wire logic [rhcb_pkg::HASH_W-1:0] b_in,
    output logic                             done,
    output logic [rhcb_pkg::HASH_W-1:0]      result
);

    logic [rhcb_pkg::HASH_W-1:0] a_reg;
    logic [rhcb_pkg::HASH_W-1:0] b_reg;
    logic [rhcb_pkg::HASH_W-1:0] acc_reg;
    logic [rhcb_pkg::HASH_W-1:0] acc_next;
    logic [2:0]                  phase_reg;
    logic                        done_reg;
    logic [31:0]                 op_x;
    logic [31:0]                 op_y;
    logic [63:0]                 prod;
    logic [rhcb_pkg::HASH_W-1:0] addend;

    // The high by high term lies wholly above bit 62 and is never formed.
    always_comb begin
        op_x   = a_reg[31:0];
        op_y   = b_reg[31:0];
        if (phase_reg[1]) begin
            op_x = {1'b0, a_reg[62:32]};
        end else if (phase_reg[2]) begin
            op_y = {1'b0, b_reg[62:32]};
        end
        prod   = 64'(op_x) * 64'(op_y);
        addend = phase_reg[0] ? prod[62:0] : {prod[30:0], 32'd0};
        acc_next = acc_reg + addend;
    end

    assign done   = done_reg;
    assign result = acc_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a_in;
            b_reg   <= b_in;
            acc_reg <= '0;
        end else if (phase_reg != 3'b000) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 3'b000;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= phase_reg[2];
            if (start) begin
                phase_reg <= 3'b001;
            end else begin
                phase_reg <= {phase_reg[1:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rhcb_back.sv */
// Back end: leaving weight, rolling hash over the window ring, cut decision and result register.
`default_nettype none

module rhcb_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire rhcb_pkg::cfg_t               cfg,
    input  wire logic                         cfg_write,
    input  wire logic                         fifo_empty,
    input  wire rhcb_pkg::item_t              fifo_item,
    output logic                              pop,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [rhcb_pkg::LEN_W-1:0]        m_chunk_length,
    output logic [rhcb_pkg::LEN_W-1:0]        m_chunk_index,
    output logic [1:0]                        m_cut_reason,
    output logic                              m_last_chunk
);

    rhcb_pkg::back_state_t state_reg, state_next;

    logic                                stale_reg, stale_next;
    logic                                wrote_reg;
    logic [rhcb_pkg::HASH_W-1:0]         weight_reg, weight_next;
    logic [rhcb_pkg::WIN_W-1:0]          wcnt_reg, wcnt_next;
    logic [rhcb_pkg::HASH_W-1:0]         hash_reg, hash_next;
    logic [rhcb_pkg::SLOT_W-1:0]         slot_reg, slot_next;
    logic [rhcb_pkg::MAX_WINDOW-1:0]     vbit_reg, vbit_next;
    logic [rhcb_pkg::LEN_W-1:0]          pos_reg, pos_next;
    logic [rhcb_pkg::LEN_W-1:0]          count_reg, count_next;
    logic                                tail_reg, tail_next;
    rhcb_pkg::item_t                     item_reg, item_next;
    logic                                mv_reg, mv_next;
    logic [rhcb_pkg::LEN_W-1:0]          olen_reg, olen_next;
    logic [rhcb_pkg::LEN_W-1:0]          oidx_reg, oidx_next;
    logic [1:0]                          oreason_reg, oreason_next;
    logic                                olast_reg, olast_next;

    logic [7:0]                          ring_mem [rhcb_pkg::MAX_WINDOW];
    logic [7:0]                          rdata_reg;
    logic [rhcb_pkg::SLOT_W-1:0]         rd_addr;
    logic                                ring_we;

    logic                                mul_start;
    logic [rhcb_pkg::HASH_W-1:0]         mul_a;
    logic                                mul_done;
    logic [rhcb_pkg::HASH_W-1:0]         mul_result;

    logic [rhcb_pkg::WIN_W-1:0]          n;
    logic [rhcb_pkg::HASH_W-1:0]         hmask;
    logic [rhcb_pkg::HASH_W-1:0]         mmask;
    logic [7:0]                          leaving;
    logic [rhcb_pkg::HASH_W-1:0]         wl_prod;
    logic [rhcb_pkg::HASH_W-1:0]         diff;
    logic                                out_free;
    logic                                above_min;
    logic                                match;
    logic                                at_max;
    logic                                candidate;
    logic                                short_tail;
    logic                                cut;
    logic                                set_tail;
    logic [1:0]                          reason;

    rhcb_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a_in    (mul_a),
        .b_in    (cfg.multiplier),
        .done    (mul_done),
        .result  (mul_result)
    );

    assign n        = rhcb_pkg::win_len(cfg.window_len);
    assign hmask    = rhcb_pkg::low_mask(cfg.hash_bits);
    assign mmask    = rhcb_pkg::low_mask(cfg.match_bits);
    assign out_free = !mv_reg || m_ready;

    assign leaving = vbit_reg[slot_reg] ? rdata_reg : 8'd0;
    assign wl_prod = weight_reg * rhcb_pkg::HASH_W'(leaving);
    assign diff    = hash_reg - wl_prod;

    assign above_min  = (pos_reg >= cfg.min_chunk);
    assign match      = ((hash_reg & mmask) == rhcb_pkg::HASH_W'(cfg.match_value));
    assign at_max     = (pos_reg >= cfg.max_chunk);
    assign candidate  = !item_reg.msg_end && !tail_reg && above_min && (match || at_max);
    assign short_tail = (item_reg.left < cfg.min_chunk);
    assign cut        = item_reg.msg_end || (candidate && !short_tail);
    assign set_tail   = candidate && short_tail;

    always_comb begin
        if (item_reg.msg_end) begin
            reason = rhcb_pkg::REASON_END;
        end else if (match) begin
            reason = rhcb_pkg::REASON_HASH;
        end else begin
            reason = rhcb_pkg::REASON_MAX;
        end
    end

    always_comb begin
        state_next   = state_reg;
        stale_next   = stale_reg;
        weight_next  = weight_reg;
        wcnt_next    = wcnt_reg;
        hash_next    = hash_reg;
        slot_next    = slot_reg;
        vbit_next    = vbit_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        tail_next    = tail_reg;
        item_next    = item_reg;
        mv_next      = mv_reg;
        olen_next    = olen_reg;
        oidx_next    = oidx_reg;
        oreason_next = oreason_reg;
        olast_next   = olast_reg;
        pop          = 1'b0;
        mul_start    = 1'b0;
        mul_a        = weight_reg;
        ring_we      = 1'b0;
        rd_addr      = slot_reg;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            rhcb_pkg::ST_IDLE: begin
                if (stale_reg) begin
                    stale_next  = 1'b0;
                    weight_next = rhcb_pkg::HASH_W'(1);
                    wcnt_next   = n - 1'b1;
                    state_next  = rhcb_pkg::ST_WLOOP;
                end else if (!fifo_empty) begin
                    pop       = 1'b1;
                    item_next = fifo_item;
                    if (fifo_item.msg_start) begin
                        hash_next  = '0;
                        pos_next   = '0;
                        count_next = '0;
                        tail_next  = 1'b0;
                        vbit_next  = '0;
                        slot_next  = '0;
                    end else if (slot_reg >= n) begin
                        slot_next = '0;
                    end
                    rd_addr    = slot_next;
                    state_next = rhcb_pkg::ST_READ;
                end
            end
            rhcb_pkg::ST_WLOOP: begin
                if (wcnt_reg == '0) begin
                    weight_next = weight_reg & hmask;
                    state_next  = rhcb_pkg::ST_IDLE;
                end else begin
                    mul_start  = 1'b1;
                    state_next = rhcb_pkg::ST_WWAIT;
                end
            end
            rhcb_pkg::ST_WWAIT: begin
                if (mul_done) begin
                    weight_next = mul_result;
                    wcnt_next   = wcnt_reg - 1'b1;
                    state_next  = rhcb_pkg::ST_WLOOP;
                end
            end
            rhcb_pkg::ST_READ: begin
                mul_start           = 1'b1;
                mul_a               = diff;
                ring_we             = 1'b1;
                vbit_next[slot_reg] = 1'b1;
                if (({1'b0, slot_reg} + 1'b1) >= n) begin
                    slot_next = '0;
                end else begin
                    slot_next = slot_reg + 1'b1;
                end
                pos_next   = pos_reg + 1'b1;
                state_next = rhcb_pkg::ST_HMUL;
            end
            rhcb_pkg::ST_HMUL: begin
                if (mul_done) begin
                    hash_next  = (mul_result + rhcb_pkg::HASH_W'(item_reg.data_byte)) & hmask;
                    state_next = rhcb_pkg::ST_DEC;
                end
            end
            rhcb_pkg::ST_DEC: begin
                if (!cut) begin
                    if (set_tail) begin
                        tail_next = 1'b1;
                    end
                    state_next = rhcb_pkg::ST_IDLE;
                end else if (out_free) begin
                    mv_next      = 1'b1;
                    olen_next    = pos_reg;
                    oidx_next    = count_reg;
                    oreason_next = reason;
                    olast_next   = item_reg.msg_end;
                    count_next   = item_reg.msg_end ? '0 : count_reg + 1'b1;
                    if (item_reg.msg_end) begin
                        tail_next = 1'b0;
                    end
                    hash_next  = '0;
                    pos_next   = '0;
                    slot_next  = '0;
                    vbit_next  = '0;
                    state_next = rhcb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rhcb_pkg::ST_IDLE;
            end
        endcase

        // Each register write is checked on its own, as the window may shrink and grow again.
        if (wrote_reg && ({1'b0, slot_reg} >= n)) begin
            slot_next = '0;
        end

        // A register write always forces the leaving weight to be worked out again.
        if (cfg_write) begin
            stale_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[slot_reg] <= item_reg.data_byte;
        end
        rdata_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        weight_reg  <= weight_next;
        item_reg    <= item_next;
        olen_reg    <= olen_next;
        oidx_reg    <= oidx_next;
        oreason_reg <= oreason_next;
        olast_reg   <= olast_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rhcb_pkg::ST_IDLE;
            stale_reg <= 1'b1;
            wrote_reg <= 1'b0;
            wcnt_reg  <= '0;
            hash_reg  <= '0;
            slot_reg  <= '0;
            vbit_reg  <= '0;
            pos_reg   <= '0;
            count_reg <= '0;
            tail_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            stale_reg <= stale_next;
            wrote_reg <= cfg_write;
            wcnt_reg  <= wcnt_next;
            hash_reg  <= hash_next;
            slot_reg  <= slot_next;
            vbit_reg  <= vbit_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            tail_reg  <= tail_next;
            mv_reg    <= mv_next;
        end
    end

    assign m_valid        = mv_reg;
    assign m_chunk_length = olen_reg;
    assign m_chunk_index  = oidx_reg;
    assign m_cut_reason   = oreason_reg;
    assign m_last_chunk   = olast_reg;

endmodule

`default_nettype wire

/* hw/rtl/rolling_hash_chunk_boundary.sv */
// Top level of the content-defined chunk boundary finder with its configuration registers.
//
// Each live message byte is queued by the front end and then handled in the back end one
// byte at a time, since each hash update feeds on the last; the 63-bit product is built
// from three 32 by 32 partial products on one shared multiplier.
// The four-entry queue lets byte requests be taken while the back end is busy or a result
// waits on m_ready. After reset and after every register write the leaving weight is
// recomputed on the same multiplier, one multiplication per window byte beyond the
// first; bytes may be queued meanwhile but are processed only afterwards. At most one
// result follows each byte.
`default_nettype none

module rolling_hash_chunk_boundary (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [rhcb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rhcb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [7:0]                      s_data_byte,
    input  wire logic                            s_first_of_message,
    input  wire logic [rhcb_pkg::LEN_W-1:0]      s_message_length,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [rhcb_pkg::LEN_W-1:0]           m_chunk_length,
    output logic [rhcb_pkg::LEN_W-1:0]           m_chunk_index,
    output logic [1:0]                           m_cut_reason,
    output logic                                 m_last_chunk
);

    rhcb_pkg::cfg_t  cfg_reg, cfg_next;
    logic            cfg_write;
    logic            push;
    rhcb_pkg::item_t push_item;
    logic            fifo_full;
    logic            fifo_empty;
    logic            pop;
    rhcb_pkg::item_t head_item;

    always_comb begin
        cfg_next  = cfg_reg;
        cfg_write = 1'b0;
        if (cfg_we) begin
            cfg_write = 1'b1;
            unique case (cfg_index)
                rhcb_pkg::CFG_MULTIPLIER:  cfg_next.multiplier  = cfg_wdata;
                rhcb_pkg::CFG_HASH_BITS:   cfg_next.hash_bits   = cfg_wdata[5:0];
                rhcb_pkg::CFG_WINDOW_LEN:  cfg_next.window_len  = cfg_wdata[6:0];
                rhcb_pkg::CFG_MATCH_BITS:  cfg_next.match_bits  = cfg_wdata[5:0];
                rhcb_pkg::CFG_MATCH_VALUE: cfg_next.match_value = cfg_wdata[31:0];
                rhcb_pkg::CFG_MIN_CHUNK:   cfg_next.min_chunk   = cfg_wdata[31:0];
                rhcb_pkg::CFG_MAX_CHUNK:   cfg_next.max_chunk   = cfg_wdata[31:0];
                default: begin
                    cfg_write = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.multiplier  <= 63'd257;
            cfg_reg.hash_bits   <= 6'd63;
            cfg_reg.window_len  <= 7'd48;
            cfg_reg.match_bits  <= 6'd13;
            cfg_reg.match_value <= 32'd0;
            cfg_reg.min_chunk   <= 32'd2048;
            cfg_reg.max_chunk   <= 32'd65536;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rhcb_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_first_of_message (s_first_of_message),
        .s_message_length   (s_message_length),
        .fifo_full          (fifo_full),
        .push               (push),
        .push_item          (push_item)
    );

    rhcb_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .empty     (fifo_empty),
        .head_item (head_item)
    );

    rhcb_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .cfg_write      (cfg_write),
        .fifo_empty     (fifo_empty),
        .fifo_item      (head_item),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_chunk_length (m_chunk_length),
        .m_chunk_index  (m_chunk_index),
        .m_cut_reason   (m_cut_reason),
        .m_last_chunk   (m_last_chunk)
    );

endmodule

`default_nettype wire
